### hw/rtl/plb_pkg.sv
// Shared types and codes for the price level book.
// No dependencies; used by plb_ctrl, plb_checker and the testbench by scoped names.
package plb_pkg;

    // Input item commands
    localparam logic [2:0] CMD_SNAP_BEGIN  = 3'd0;
    localparam logic [2:0] CMD_SNAP_LEVEL  = 3'd1;
    localparam logic [2:0] CMD_DEPTH_BEGIN = 3'd2;
    localparam logic [2:0] CMD_DEPTH_LEVEL = 3'd3;
    localparam logic [2:0] CMD_QUERY       = 3'd4;
    localparam logic [2:0] CMD_DUMP        = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_VALID = 3'd1;
    localparam logic [2:0] ST_OUTDATED  = 3'd2;
    localparam logic [2:0] ST_GAP       = 3'd3;
    localparam logic [2:0] ST_EVICTED   = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;

    // Result record kinds
    localparam logic [1:0] RK_PLAIN = 2'd0;
    localparam logic [1:0] RK_CLEAR = 2'd1;
    localparam logic [1:0] RK_ADD   = 2'd2;

    localparam int          PRICE_W    = 32;
    localparam int          QTY_W      = 32;
    localparam int          ENTRY_W    = PRICE_W + QTY_W;
    localparam logic [31:0] PRICE_NONE = 32'hFFFF_FFFF;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SC_RD,
        S_SC_CHK,
        S_ACT,
        S_UP_CHK,
        S_UP_WR,
        S_RM_CHK,
        S_RM_WR,
        S_RESP,
        S_D_CLR,
        S_D_ENT
    } t_state;

endpackage

### hw/rtl/plb_level_mem.sv
// Level store: synchronous RAM of price/quantity entries, registered read.
// Depends on nothing; instantiated by plb_ctrl.
module plb_level_mem #(
    parameter int AW = 5,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/plb_ctrl.sv
// Book sequencer: sequence check, sorted insert/remove, query and dump
// over the level store. Depends on plb_pkg and plb_level_mem.
module plb_ctrl #(
    parameter int LEVELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [2:0]  i_command,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic [63:0] i_first_id,
    input  logic [63:0] i_final_id,
    output logic        o_busy,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [1:0]  o_record_kind,
    output logic        o_record_side,
    output logic [31:0] o_record_price,
    output logic [31:0] o_record_quantity,
    output logic [4:0]  o_priority_res,
    output logic [31:0] o_best_bid,
    output logic [31:0] o_best_ask,
    output logic        o_refresh_needed,
    output logic        o_last
);
    localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(LEVELS + 1);
    localparam int AW = IW + 1;
    localparam logic [CW-1:0] LV = CW'(LEVELS);
    localparam logic [CW-1:0] C_ONE = CW'(1);

    plb_pkg::t_state r_state, n_state;
    logic [2:0]  r_cmd, n_cmd;
    logic        r_side, n_side;
    logic [31:0] r_price, n_price;
    logic [31:0] r_qty, n_qty;
    logic [2:0]  r_st, n_st;
    logic [31:0] r_rq, n_rq;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic        r_match, n_match;
    logic [CW-1:0] r_bid_cnt, n_bid_cnt;
    logic [CW-1:0] r_ask_cnt, n_ask_cnt;
    logic [63:0] r_last_id, n_last_id;
    logic        r_valid, n_valid;
    logic        r_refresh, n_refresh;
    logic        r_upd, n_upd;
    logic [31:0] r_best_bid, n_best_bid;
    logic [31:0] r_best_ask, n_best_ask;
    logic        r_dside, n_dside;

    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [plb_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;
    logic                       wr_side;
    logic [CW-1:0]              wr_idx;

    logic [CW-1:0] cnt;
    logic [31:0]   rd_price, rd_qty;
    logic          is_set, is_query, better, d_last;
    logic [64:0]   next_id;

    plb_level_mem #(.AW(AW), .DW(plb_pkg::ENTRY_W)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign cnt      = r_side ? r_ask_cnt : r_bid_cnt;
    assign rd_price = mem_rdata[plb_pkg::ENTRY_W-1:plb_pkg::QTY_W];
    assign rd_qty   = mem_rdata[plb_pkg::QTY_W-1:0];
    assign better   = r_side ? (r_price < rd_price) : (r_price > rd_price);
    assign is_query = (r_cmd == plb_pkg::CMD_QUERY);
    assign is_set   = (r_cmd == plb_pkg::CMD_SNAP_LEVEL) || (r_qty != 32'd0);
    assign next_id  = {1'b0, r_last_id} + 65'd1;
    assign mem_waddr = {wr_side, wr_idx[IW-1:0]};
    assign o_busy   = (r_state != plb_pkg::S_IDLE);

    // Book-wide fields shown on every result
    assign o_best_bid = (r_valid && r_bid_cnt != '0) ? r_best_bid : plb_pkg::PRICE_NONE;
    assign o_best_ask = (r_valid && r_ask_cnt != '0) ? r_best_ask : plb_pkg::PRICE_NONE;
    assign o_refresh_needed = r_refresh;

    // Hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= plb_pkg::S_IDLE;
            r_bid_cnt <= '0;
            r_ask_cnt <= '0;
            r_last_id <= '0;
            r_valid   <= 1'b0;
            r_refresh <= 1'b0;
            r_upd     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bid_cnt <= n_bid_cnt;
            r_ask_cnt <= n_ask_cnt;
            r_last_id <= n_last_id;
            r_valid   <= n_valid;
            r_refresh <= n_refresh;
            r_upd     <= n_upd;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_side     <= n_side;
        r_price    <= n_price;
        r_qty      <= n_qty;
        r_st       <= n_st;
        r_rq       <= n_rq;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_match    <= n_match;
        r_best_bid <= n_best_bid;
        r_best_ask <= n_best_ask;
        r_dside    <= n_dside;
    end

    // Sequence the item over the level store
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_side    = r_side;
        n_price   = r_price;
        n_qty     = r_qty;
        n_st      = r_st;
        n_rq      = r_rq;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_match   = r_match;
        n_bid_cnt = r_bid_cnt;
        n_ask_cnt = r_ask_cnt;
        n_last_id = r_last_id;
        n_valid   = r_valid;
        n_refresh = r_refresh;
        n_upd     = r_upd;
        n_best_bid = r_best_bid;
        n_best_ask = r_best_ask;
        n_dside   = r_dside;
        mem_we    = 1'b0;
        mem_wdata = mem_rdata;
        wr_side   = r_side;
        wr_idx    = r_idx;
        mem_re    = 1'b0;
        mem_raddr = {r_side, r_idx[IW-1:0]};
        d_last    = 1'b0;
        o_valid           = 1'b0;
        o_status          = plb_pkg::ST_OK;
        o_record_kind     = plb_pkg::RK_PLAIN;
        o_record_side     = 1'b0;
        o_record_price    = 32'd0;
        o_record_quantity = 32'd0;
        o_priority_res    = 5'd0;
        o_last            = 1'b0;

        unique case (r_state)
            plb_pkg::S_IDLE: begin
                if (i_go) begin
                    n_cmd   = i_command;
                    n_side  = i_side;
                    n_price = i_price;
                    n_qty   = i_quantity;
                    n_st    = plb_pkg::ST_OK;
                    n_rq    = 32'd0;
                    n_idx   = '0;
                    n_state = plb_pkg::S_RESP;
                    unique case (i_command)
                        plb_pkg::CMD_SNAP_BEGIN: begin
                            n_bid_cnt = '0;
                            n_ask_cnt = '0;
                            n_last_id = i_final_id;
                            n_valid   = 1'b1;
                            n_refresh = 1'b0;
                            n_upd     = 1'b0;
                        end
                        plb_pkg::CMD_SNAP_LEVEL: begin
                            if (i_quantity == 32'd0) begin
                                n_st = plb_pkg::ST_IGNORED;
                            end else begin
                                n_state = plb_pkg::S_SC_RD;
                            end
                        end
                        plb_pkg::CMD_DEPTH_BEGIN: begin
                            n_upd = 1'b0;
                            if (!r_valid) begin
                                n_st      = plb_pkg::ST_NOT_VALID;
                                n_refresh = 1'b1;
                            end else if ({1'b0, i_final_id} < next_id) begin
                                n_st = plb_pkg::ST_OUTDATED;
                            end else if ({1'b0, i_first_id} > next_id) begin
                                n_st      = plb_pkg::ST_GAP;
                                n_refresh = 1'b1;
                            end else begin
                                n_last_id = i_final_id;
                                n_upd     = 1'b1;
                            end
                        end
                        plb_pkg::CMD_DEPTH_LEVEL: begin
                            if (!r_upd) begin
                                n_st = plb_pkg::ST_IGNORED;
                            end else begin
                                n_state = plb_pkg::S_SC_RD;
                            end
                        end
                        plb_pkg::CMD_QUERY: begin
                            if (!r_valid) begin
                                n_st = plb_pkg::ST_NOT_VALID;
                            end else begin
                                n_state = plb_pkg::S_SC_RD;
                            end
                        end
                        plb_pkg::CMD_DUMP: begin
                            n_state = r_valid ? plb_pkg::S_D_CLR : plb_pkg::S_IDLE;
                        end
                        default: begin
                            n_st = plb_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end

            // Scan the side for the price or its slot
            plb_pkg::S_SC_RD: begin
                if (r_idx == cnt) begin
                    n_match = 1'b0;
                    n_pos   = cnt;
                    n_state = plb_pkg::S_ACT;
                end else begin
                    mem_re  = 1'b1;
                    n_state = plb_pkg::S_SC_CHK;
                end
            end
            plb_pkg::S_SC_CHK: begin
                if (rd_price == r_price) begin
                    n_match = 1'b1;
                    n_pos   = r_idx;
                    // Only a query reports the quantity found
                    if (is_query) n_rq = rd_qty;
                    n_state = plb_pkg::S_ACT;
                end else if (better) begin
                    n_match = 1'b0;
                    n_pos   = r_idx;
                    n_state = plb_pkg::S_ACT;
                end else begin
                    n_idx   = r_idx + C_ONE;
                    n_state = plb_pkg::S_SC_RD;
                end
            end

            // Decide the change once the scan is done
            plb_pkg::S_ACT: begin
                n_state = plb_pkg::S_RESP;
                if (is_query) begin
                    n_st = plb_pkg::ST_OK;
                end else if (!is_set) begin
                    if (r_match) begin
                        n_idx   = r_pos;
                        n_state = plb_pkg::S_RM_CHK;
                    end
                end else if (r_match) begin
                    mem_we    = 1'b1;
                    wr_idx    = r_pos;
                    mem_wdata = {r_price, r_qty};
                end else if (cnt != LV) begin
                    n_idx   = cnt;
                    n_state = plb_pkg::S_UP_CHK;
                end else if (r_pos == cnt) begin
                    n_st = plb_pkg::ST_EVICTED;
                end else begin
                    n_st    = plb_pkg::ST_EVICTED;
                    n_idx   = LV - C_ONE;
                    n_state = plb_pkg::S_UP_CHK;
                end
            end

            // Shift worse levels down one place, then place the new one
            plb_pkg::S_UP_CHK: begin
                if (r_idx == r_pos) begin
                    mem_we    = 1'b1;
                    mem_wdata = {r_price, r_qty};
                    if (cnt != LV) begin
                        if (r_side) n_ask_cnt = r_ask_cnt + C_ONE;
                        else        n_bid_cnt = r_bid_cnt + C_ONE;
                    end
                    n_state = plb_pkg::S_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = {r_side, (r_idx[IW-1:0] - 1'b1)};
                    n_state   = plb_pkg::S_UP_WR;
                end
            end
            plb_pkg::S_UP_WR: begin
                mem_we  = 1'b1;
                n_idx   = r_idx - C_ONE;
                n_state = plb_pkg::S_UP_CHK;
            end

            // Close the gap left by a removed level
            plb_pkg::S_RM_CHK: begin
                if (r_idx + C_ONE == cnt) begin
                    if (r_side) n_ask_cnt = r_ask_cnt - C_ONE;
                    else        n_bid_cnt = r_bid_cnt - C_ONE;
                    n_state = plb_pkg::S_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = {r_side, (r_idx[IW-1:0] + 1'b1)};
                    n_state   = plb_pkg::S_RM_WR;
                end
            end
            plb_pkg::S_RM_WR: begin
                mem_we  = 1'b1;
                n_idx   = r_idx + C_ONE;
                n_state = plb_pkg::S_RM_CHK;
            end

            // Single plain result
            plb_pkg::S_RESP: begin
                o_valid           = 1'b1;
                o_status          = r_st;
                o_record_quantity = r_rq;
                o_last            = 1'b1;
                n_state           = plb_pkg::S_IDLE;
            end

            // Dump: clear record, prefetch first level
            plb_pkg::S_D_CLR: begin
                o_valid       = 1'b1;
                o_record_kind = plb_pkg::RK_CLEAR;
                o_last        = (r_bid_cnt == '0) && (r_ask_cnt == '0);
                n_dside       = (r_bid_cnt == '0);
                n_idx         = '0;
                mem_re        = 1'b1;
                mem_raddr     = {(r_bid_cnt == '0), {IW{1'b0}}};
                n_state       = o_last ? plb_pkg::S_IDLE : plb_pkg::S_D_ENT;
            end

            // Dump: one level per cycle, next read in flight
            plb_pkg::S_D_ENT: begin
                if (r_dside) begin
                    d_last = (r_idx + C_ONE == r_ask_cnt);
                end else begin
                    d_last = (r_idx + C_ONE == r_bid_cnt) && (r_ask_cnt == '0);
                end
                o_valid           = 1'b1;
                o_record_kind     = plb_pkg::RK_ADD;
                o_record_side     = r_dside;
                o_record_price    = rd_price;
                o_record_quantity = rd_qty;
                o_priority_res    = 5'(r_idx) + 5'd1;
                o_last            = d_last;
                if (!r_dside && (r_idx + C_ONE == r_bid_cnt)) begin
                    n_dside = 1'b1;
                    n_idx   = '0;
                end else begin
                    n_idx   = r_idx + C_ONE;
                end
                mem_re    = !d_last;
                mem_raddr = {n_dside, n_idx[IW-1:0]};
                n_state   = d_last ? plb_pkg::S_IDLE : plb_pkg::S_D_ENT;
            end

            default: begin
                n_state = plb_pkg::S_IDLE;
            end
        endcase

        // Track the best price whenever the top entry of a side is written
        if (mem_we && wr_idx == '0) begin
            if (wr_side) n_best_ask = mem_wdata[plb_pkg::ENTRY_W-1:plb_pkg::QTY_W];
            else         n_best_bid = mem_wdata[plb_pkg::ENTRY_W-1:plb_pkg::QTY_W];
        end
    end
endmodule

### hw/rtl/price_level_book_with_sequence_check.sv
// Price level order book with update sequence check: top level.
// Depends on plb_ctrl (which holds the level store).
//
// Usage: present an item on the command ports with start high; it is
// taken at a clock edge where busy is low. Results appear one per cycle
// with o_valid high, o_last marking the final one of the item; the
// receiver cannot hold them off. Every command gives one plain result,
// except a dump of a valid book, which streams a clear record followed
// by each bid and each ask level best first, one level per cycle, and a
// dump of an invalid book, which gives none.
// Header, snapshot begin and ignored items show their result in the cycle
// after acceptance. Level commands and queries scan the side in the level
// RAM entry by entry; an insert or remove then moves each displaced entry
// with a read and a write. A dump of n levels streams its n+1 results back
// to back. The user writes the instrument register with i_cfg_we only
// while the block is idle; the block itself does not enforce this.
// Reset empties the book, marks it not valid and clears the flags;
// level RAM contents are not cleared, entries are read only below count.
module price_level_book_with_sequence_check #(
    parameter int LEVELS_PER_SIDE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic [63:0] i_first_id,
    input  logic [63:0] i_final_id,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [1:0]  o_record_kind,
    output logic        o_record_side,
    output logic [31:0] o_record_price,
    output logic [31:0] o_record_quantity,
    output logic [4:0]  o_priority_res,
    output logic [31:0] o_best_bid,
    output logic [31:0] o_best_ask,
    output logic        o_refresh_needed,
    output logic [15:0] o_instrument,
    output logic        o_last
);
    logic [15:0] r_instrument;
    logic        go;

    // Hold the instrument register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_instrument <= 16'd0;
        end else if (i_cfg_we) begin
            r_instrument <= i_cfg_wdata;
        end
    end

    assign go           = start && !busy;
    assign o_instrument = r_instrument;

    plb_ctrl #(.LEVELS(LEVELS_PER_SIDE)) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (go),
        .i_command        (i_command),
        .i_side           (i_side),
        .i_price          (i_price),
        .i_quantity       (i_quantity),
        .i_first_id       (i_first_id),
        .i_final_id       (i_final_id),
        .o_busy           (busy),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_record_kind    (o_record_kind),
        .o_record_side    (o_record_side),
        .o_record_price   (o_record_price),
        .o_record_quantity(o_record_quantity),
        .o_priority_res   (o_priority_res),
        .o_best_bid       (o_best_bid),
        .o_best_ask       (o_best_ask),
        .o_refresh_needed (o_refresh_needed),
        .o_last           (o_last)
    );
endmodule

### hw/rtl/plb_checker.sv
// Port-level checks for the price level book, bound to the top level.
// Depends on plb_pkg and price_level_book_with_sequence_check.
module plb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_valid,
    input logic       o_last,
    input logic [2:0] o_status,
    input logic [1:0] o_record_kind
);
    // Results only come while an item is in hand
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside an item");

    // Dump results stream without gaps
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid) else $error("gap in result stream");

    // Final result ends the item
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !busy && !o_valid) else $error("busy after last");

    // Clear records carry an ok status
    a_clear_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind == plb_pkg::RK_CLEAR |-> o_status == plb_pkg::ST_OK)
        else $error("clear record with bad status");
endmodule

bind price_level_book_with_sequence_check plb_checker u_plb_checker (.*);

### tb/tb.sv
// Self-checking testbench for price_level_book_with_sequence_check.
// Depends on plb_pkg and the block's RTL; a built-in book predictor checks every result.
module tb;

    localparam int LEVELS = 16;
    // Command codes that the block does not define
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
    localparam logic [63:0] ID_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] PRICE_TOP = 32'hFFFF_FFFE;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  kind;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        logic [4:0]  prio;
        logic [31:0] best_bid;
        logic [31:0] best_ask;
        logic        refresh;
        logic [15:0] instrument;
        logic        last;
    } t_book_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_command = '0;
    logic        i_side = 1'b0;
    logic [31:0] i_price = '0;
    logic [31:0] i_quantity = '0;
    logic [63:0] i_first_id = '0;
    logic [63:0] i_final_id = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [1:0]  o_record_kind;
    logic        o_record_side;
    logic [31:0] o_record_price;
    logic [31:0] o_record_quantity;
    logic [4:0]  o_priority_res;
    logic [31:0] o_best_bid;
    logic [31:0] o_best_ask;
    logic        o_refresh_needed;
    logic [15:0] o_instrument;
    logic        o_last;

    price_level_book_with_sequence_check #(.LEVELS_PER_SIDE(LEVELS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy), .i_command(i_command), .i_side(i_side),
        .i_price(i_price), .i_quantity(i_quantity), .i_first_id(i_first_id),
        .i_final_id(i_final_id), .o_valid(o_valid), .o_status(o_status),
        .o_record_kind(o_record_kind), .o_record_side(o_record_side),
        .o_record_price(o_record_price), .o_record_quantity(o_record_quantity),
        .o_priority_res(o_priority_res), .o_best_bid(o_best_bid), .o_best_ask(o_best_ask),
        .o_refresh_needed(o_refresh_needed), .o_instrument(o_instrument), .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted book state
    logic [31:0] lvl_px [2][LEVELS];
    logic [31:0] lvl_qty [2][LEVELS];
    int          lvl_cnt [2];
    logic [63:0] applied_id;
    logic        book_ok;
    logic        refresh_pend;
    logic        hdr_ok;
    logic [15:0] instr_reg;

    t_book_result pending_results[$];
    int           fail_count = 0;
    int           burst_left = 0;
    logic         sending = 1'b0;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic logic ranks_above(input logic s, input logic [31:0] a,
                                         input logic [31:0] b);
        return s ? (a < b) : (a > b);
    endfunction

    function automatic void push_result(input logic [2:0] st, input logic [1:0] kind,
                                        input logic s, input logic [31:0] px,
                                        input logic [31:0] q, input logic [4:0] prio,
                                        input logic last);
        t_book_result r;
        r.status = st; r.kind = kind; r.side = s; r.price = px; r.qty = q; r.prio = prio;
        r.best_bid = (book_ok && lvl_cnt[0] > 0) ? lvl_px[0][0] : plb_pkg::PRICE_NONE;
        r.best_ask = (book_ok && lvl_cnt[1] > 0) ? lvl_px[1][0] : plb_pkg::PRICE_NONE;
        r.refresh = refresh_pend;
        r.instrument = instr_reg;
        r.last = last;
        pending_results = {pending_results, r};
    endfunction

    // Set a level, evicting the worst one when the side is full
    function automatic logic [2:0] book_set(input logic s, input logic [31:0] px,
                                            input logic [31:0] q);
        int n, pos, i;
        n = lvl_cnt[s];
        for (i = 0; i < n; i++) begin
            if (lvl_px[s][i] == px) begin
                lvl_qty[s][i] = q;
                return plb_pkg::ST_OK;
            end
        end
        pos = n;
        for (i = n - 1; i >= 0; i--)
            if (ranks_above(s, px, lvl_px[s][i])) pos = i;
        if (n < LEVELS) begin
            for (i = n; i > pos; i--) begin
                lvl_px[s][i] = lvl_px[s][i-1];
                lvl_qty[s][i] = lvl_qty[s][i-1];
            end
            lvl_px[s][pos] = px;
            lvl_qty[s][pos] = q;
            lvl_cnt[s] = n + 1;
            return plb_pkg::ST_OK;
        end
        if (pos >= LEVELS) return plb_pkg::ST_EVICTED;
        for (i = LEVELS - 1; i > pos; i--) begin
            lvl_px[s][i] = lvl_px[s][i-1];
            lvl_qty[s][i] = lvl_qty[s][i-1];
        end
        lvl_px[s][pos] = px;
        lvl_qty[s][pos] = q;
        return plb_pkg::ST_EVICTED;
    endfunction

    function automatic void book_remove(input logic s, input logic [31:0] px);
        int n, i, j;
        n = lvl_cnt[s];
        for (i = 0; i < n; i++) begin
            if (lvl_px[s][i] == px) begin
                for (j = i; j + 1 < n; j++) begin
                    lvl_px[s][j] = lvl_px[s][j+1];
                    lvl_qty[s][j] = lvl_qty[s][j+1];
                end
                lvl_cnt[s] = n - 1;
                return;
            end
        end
    endfunction

    // Apply one accepted item to the predicted book and queue its results
    function automatic void predict_book(input logic [2:0] cmd, input logic s,
                                         input logic [31:0] px, input logic [31:0] q,
                                         input logic [63:0] first, input logic [63:0] fin);
        logic [2:0]  st;
        logic [31:0] found;
        int i, nb, na;
        st = plb_pkg::ST_OK;
        found = '0;
        case (cmd)
            plb_pkg::CMD_SNAP_BEGIN: begin
                lvl_cnt[0] = 0; lvl_cnt[1] = 0;
                applied_id = fin; book_ok = 1'b1; refresh_pend = 1'b0; hdr_ok = 1'b0;
            end
            plb_pkg::CMD_SNAP_LEVEL: st = (q == 0) ? plb_pkg::ST_IGNORED : book_set(s, px, q);
            plb_pkg::CMD_DEPTH_BEGIN: begin
                hdr_ok = 1'b0;
                if (!book_ok) begin
                    st = plb_pkg::ST_NOT_VALID; refresh_pend = 1'b1;
                end else if (applied_id == ID_MAX || fin < applied_id + 64'd1) begin
                    st = plb_pkg::ST_OUTDATED;
                end else if (first > applied_id + 64'd1) begin
                    st = plb_pkg::ST_GAP; refresh_pend = 1'b1;
                end else begin
                    applied_id = fin; hdr_ok = 1'b1;
                end
            end
            plb_pkg::CMD_DEPTH_LEVEL: begin
                if (!hdr_ok) st = plb_pkg::ST_IGNORED;
                else if (q == 0) book_remove(s, px);
                else st = book_set(s, px, q);
            end
            plb_pkg::CMD_QUERY: begin
                if (!book_ok) st = plb_pkg::ST_NOT_VALID;
                else
                    for (i = lvl_cnt[s] - 1; i >= 0; i--)
                        if (lvl_px[s][i] == px) found = lvl_qty[s][i];
            end
            plb_pkg::CMD_DUMP: begin
                if (!book_ok) return;
                nb = lvl_cnt[0];
                na = lvl_cnt[1];
                push_result(plb_pkg::ST_OK, plb_pkg::RK_CLEAR, 1'b0, '0, '0, '0,
                            (nb + na == 0));
                for (i = 0; i < nb; i++)
                    push_result(plb_pkg::ST_OK, plb_pkg::RK_ADD, 1'b0, lvl_px[0][i],
                                lvl_qty[0][i], 5'(i + 1), (na == 0 && i + 1 == nb));
                for (i = 0; i < na; i++)
                    push_result(plb_pkg::ST_OK, plb_pkg::RK_ADD, 1'b1, lvl_px[1][i],
                                lvl_qty[1][i], 5'(i + 1), (i + 1 == na));
                return;
            end
            default: st = plb_pkg::ST_IGNORED;
        endcase
        push_result(st, plb_pkg::RK_PLAIN, 1'b0, '0, found, '0, 1'b1);
    endfunction

    // Send one item, idling between bursts
    task automatic send_item(input logic [2:0] cmd, input logic s, input logic [31:0] px,
                             input logic [31:0] q, input logic [63:0] first,
                             input logic [63:0] fin);
        i_command <= cmd; i_side <= s; i_price <= px; i_quantity <= q;
        i_first_id <= first; i_final_id <= fin;
        start <= 1'b1;
        sending = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_book(cmd, s, px, q, first, fin);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            sending = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 4);
        end
    endtask

    // Drop start, drain every result and let the block settle
    task automatic wait_idle();
        if (sending) begin
            start <= 1'b0;
            sending = 1'b0;
        end
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_instrument(input logic [15:0] v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        instr_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_book_result got, want;
        if (i_rst_n && o_valid) begin
            got = {o_status, o_record_kind, o_record_side, o_record_price, o_record_quantity,
                   o_priority_res, o_best_bid, o_best_ask, o_refresh_needed, o_instrument,
                   o_last};
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) report($sformatf("got %h want %h", got, want));
            end
        end
    end

    function automatic logic [31:0] pick_price();
        logic [31:0] p;
        if ($urandom_range(0, 6) != 0) return 32'd1000 + $urandom_range(0, 40);
        p = $urandom;
        return (p > PRICE_TOP) ? PRICE_TOP : p;
    endfunction

    function automatic logic [31:0] pick_qty();
        case ($urandom_range(0, 9))
            0, 1: return '0;
            2: return $urandom;
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    // Out of reset: book not valid, headers and levels refused
    task automatic test_invalid_book();
        send_item(plb_pkg::CMD_QUERY, 1'b0, 32'd5, '0, '0, '0);
        send_item(plb_pkg::CMD_DUMP, 1'b0, '0, '0, '0, '0);
        send_item(plb_pkg::CMD_DEPTH_LEVEL, 1'b1, 32'd7, 32'd3, '0, '0);
        send_item(plb_pkg::CMD_DEPTH_BEGIN, 1'b0, '0, '0, 64'd1, 64'd1);
        send_item(CMD_UNUSED_6, 1'b1, PRICE_TOP, 32'hFFFF_FFFF, ID_MAX, ID_MAX);
        send_item(CMD_UNUSED_7, 1'b0, '0, '0, '0, '0);
    endtask

    // Fill the bid side past its depth: evict worst, drop a worse price
    task automatic test_full_side();
        int i;
        send_item(plb_pkg::CMD_SNAP_BEGIN, 1'b0, '0, '0, '0, 64'd100);
        send_item(plb_pkg::CMD_SNAP_LEVEL, 1'b0, 32'd50, '0, '0, '0);
        for (i = 0; i < LEVELS; i++)
            send_item(plb_pkg::CMD_SNAP_LEVEL, 1'b0, 32'd100 + i, 32'd10 + i, '0, '0);
        send_item(plb_pkg::CMD_SNAP_LEVEL, 1'b0, 32'd50, 32'd1, '0, '0);
        send_item(plb_pkg::CMD_SNAP_LEVEL, 1'b0, PRICE_TOP, 32'hFFFF_FFFF, '0, '0);
        send_item(plb_pkg::CMD_SNAP_LEVEL, 1'b1, '0, 32'd9, '0, '0);
        send_item(plb_pkg::CMD_QUERY, 1'b0, 32'd110, '0, '0, '0);
        send_item(plb_pkg::CMD_DUMP, 1'b0, '0, '0, '0, '0);
    endtask

    // Header checks: outdated, gap, accepted, removal, id at its top value
    task automatic test_depth_sequence();
        send_item(plb_pkg::CMD_DEPTH_BEGIN, 1'b0, '0, '0, 64'd90, 64'd100);
        send_item(plb_pkg::CMD_DEPTH_BEGIN, 1'b0, '0, '0, 64'd105, 64'd110);
        send_item(plb_pkg::CMD_DEPTH_BEGIN, 1'b0, '0, '0, 64'd95, 64'd120);
        send_item(plb_pkg::CMD_DEPTH_LEVEL, 1'b0, 32'd777, '0, '0, '0);
        send_item(plb_pkg::CMD_DEPTH_LEVEL, 1'b0, 32'd110, '0, '0, '0);
        send_item(plb_pkg::CMD_DEPTH_LEVEL, 1'b1, 32'd30, 32'd4, '0, '0);
        send_item(plb_pkg::CMD_DUMP, 1'b0, '0, '0, '0, '0);
        send_item(plb_pkg::CMD_SNAP_BEGIN, 1'b0, '0, '0, '0, ID_MAX);
        send_item(plb_pkg::CMD_DEPTH_BEGIN, 1'b0, '0, '0, '0, ID_MAX);
        send_item(plb_pkg::CMD_DUMP, 1'b0, '0, '0, '0, '0);
    endtask

    // Random sessions of snapshots and depth updates, with noise
    task automatic test_random_sessions(input int n_items);
        int sent, k, j;
        logic [63:0] first, fin;
        sent = 0;
        while (sent < n_items) begin
            k = $urandom_range(0, 99);
            if (k < 8) begin
                fin = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                  : 64'($urandom_range(0, 1000));
                send_item(plb_pkg::CMD_SNAP_BEGIN, 1'($urandom), pick_price(), pick_qty(),
                          {$urandom, $urandom}, fin);
                sent++;
                repeat ($urandom_range(0, 8)) begin
                    send_item(plb_pkg::CMD_SNAP_LEVEL, 1'($urandom), pick_price(),
                              pick_qty(), '0, '0);
                    sent++;
                end
            end else if (k < 55) begin
                first = applied_id + 64'd1 - 64'($urandom_range(0, 3));
                fin = applied_id + 64'($urandom_range(1, 6));
                if ($urandom_range(0, 9) == 0) first = applied_id + 64'($urandom_range(2, 9));
                if ($urandom_range(0, 9) == 0) fin = applied_id - 64'($urandom_range(0, 3));
                send_item(plb_pkg::CMD_DEPTH_BEGIN, 1'($urandom), pick_price(), pick_qty(),
                          first, fin);
                sent++;
                for (j = $urandom_range(1, 5); j > 0; j--) begin
                    send_item(plb_pkg::CMD_DEPTH_LEVEL, 1'($urandom), pick_price(),
                              pick_qty(), '0, '0);
                    sent++;
                end
            end else if (k < 70) begin
                send_item(plb_pkg::CMD_QUERY, 1'($urandom), pick_price(), '0, '0, '0);
                sent++;
            end else if (k < 78) begin
                send_item(plb_pkg::CMD_DUMP, 1'($urandom), '0, '0, '0, '0);
                sent++;
            end else if (k < 90) begin
                send_item(plb_pkg::CMD_SNAP_LEVEL, 1'($urandom), pick_price(), pick_qty(),
                          '0, '0);
                sent++;
            end else begin
                send_item(3'($urandom_range(0, 7)), 1'($urandom), pick_price(), $urandom,
                          {$urandom, $urandom}, {$urandom, $urandom});
                sent++;
            end
        end
    endtask

    initial begin
        instr_reg = '0;
        lvl_cnt[0] = 0; lvl_cnt[1] = 0;
        applied_id = '0; book_ok = 1'b0; refresh_pend = 1'b0; hdr_ok = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_invalid_book();
        set_instrument(16'hFFFF);
        test_full_side();
        test_depth_sequence();
        set_instrument(16'h0000);
        test_random_sessions(48);
        set_instrument(16'($urandom));
        test_random_sessions(48);
        set_instrument(16'hFFFF);
        test_random_sessions(48);
        wait_idle();

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard stop for a hung run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
